### hw/rtl/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg
// shared sizes and constants for the linear scan register assigner
// ----------------------------------------------------------------------------
package lsra_pkg;

  // register file being handed out and position width
  localparam int NUM_REGS  = 64;
  localparam int POS_WIDTH = 16;

  // derived widths
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int HW_W      = $clog2(NUM_REGS + 1);

  // fixed field widths of the channels and the count register
  localparam int COUNT_W = 7;
  localparam int AREG_W  = 6;
  localparam int USED_W  = 7;

  // width wide enough to compare the count with the register range
  localparam int LIM_W = (HW_W > COUNT_W) ? HW_W : COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

endpackage

### hw/rtl/lsra_in_if.sv
// ----------------------------------------------------------------------------
// lsra_in_if
// live range channel: valid/ready handshake with one range per word
// ----------------------------------------------------------------------------
interface lsra_in_if import lsra_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic                 first_of_function;
  logic [POS_WIDTH-1:0] range_start;
  logic [POS_WIDTH-1:0] range_end;

  modport source (
    output valid, first_of_function, range_start, range_end,
    input  ready
  );

  modport sink (
    input  valid, first_of_function, range_start, range_end,
    output ready
  );
endinterface

### hw/rtl/lsra_out_if.sv
// ----------------------------------------------------------------------------
// lsra_out_if
// assignment result channel: valid/ready handshake with one result per word
// ----------------------------------------------------------------------------
interface lsra_out_if import lsra_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [AREG_W-1:0] assigned_register;
  logic              no_free_register;
  logic [USED_W-1:0] registers_used;

  modport source (
    output valid, assigned_register, no_free_register, registers_used,
    input  ready
  );

  modport sink (
    input  valid, assigned_register, no_free_register, registers_used,
    output ready
  );
endinterface

### hw/rtl/lsra_ram.sv
// ----------------------------------------------------------------------------
// lsra_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module lsra_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/linear_scan_register_assign.sv
// ----------------------------------------------------------------------------
// linear_scan_register_assign
// linear scan register assignment over live ranges, no spilling
// ----------------------------------------------------------------------------
// usage:
//   range_in carries one live range per word (first_of_function, range_start,
//   range_end), in order of start. result_out returns one word per range:
//   the assigned register, a no-free flag and the high-water register count.
//   cfg_write/cfg_data set register_count (saturates at the register file
//   size); write it only while the block is idle.
// sequencing:
//   an accepted range walks the whole end-position memory, one entry per
//   cycle, then passes the drain and commit states before its result word
//   is registered; the next range is accepted only after that commit.
//   one range is worked on at a time; range_in.ready is high only when idle.
// reset:
//   all registers free, high-water zero, register_count back to 64. the end
//   positions are only read for busy registers and need no clearing.
// stall:
//   the result sits in an output register; a new range is accepted while it
//   waits, and the next result holds in its last step until the slot frees.
// ----------------------------------------------------------------------------
module linear_scan_register_assign import lsra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_data,
  lsra_in_if.sink            range_in,
  lsra_out_if.source         result_out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;

  // configuration
  logic [COUNT_W-1:0] register_count;
  logic [LIM_W-1:0]   count_ext;
  logic [LIM_W-1:0]   limit;

  // per-range context latched at accept
  logic [POS_WIDTH-1:0] start_q;
  logic [POS_WIDTH-1:0] end_q;

  // allocation state held in flops; end positions live in the ram
  logic [NUM_REGS-1:0] busy_flags;
  logic [HW_W-1:0]     high_water;

  // scan pointer and the compare stage that lines up with the ram data
  logic [REG_IDX_W-1:0] scan_idx;
  logic                 chk_valid;
  logic [REG_IDX_W-1:0] chk_idx;
  logic [POS_WIDTH-1:0] rd_data;

  // lowest free register found so far in this scan
  logic                 found;
  logic [REG_IDX_W-1:0] chosen;

  logic chk_busy;
  logic chk_expire;
  logic chk_free;
  logic chk_avail;
  logic out_free;
  logic commit_go;
  logic in_accept;

  logic [HW_W-1:0] chosen_used;

  // saturate the configured count to the register file size
  assign count_ext = LIM_W'(register_count);
  assign limit     = (count_ext > LIM_W'(NUM_REGS)) ? LIM_W'(NUM_REGS) : count_ext;

  assign range_in.ready = (state == S_IDLE);
  assign in_accept      = range_in.valid && range_in.ready;

  // expiry check for the entry whose end position just came out of the ram
  always_comb begin
    chk_busy   = busy_flags[chk_idx];
    chk_expire = chk_busy && (rd_data <= start_q);
    chk_free   = !chk_busy || chk_expire;
    chk_avail  = LIM_W'(chk_idx) < limit;
  end

  // output slot is free when empty or being drained this cycle
  assign out_free    = !result_out.valid || result_out.ready;
  assign commit_go   = (state == S_COMMIT) && out_free;
  assign chosen_used = HW_W'(chosen) + HW_W'(1);

  // end positions: read one entry per cycle during the scan, written back
  // only in the commit step, so a read never meets a pending write
  lsra_ram #(
    .WIDTH (POS_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_until_ram (
    .clk   (clk),
    .we    (commit_go && found),
    .waddr (chosen),
    .wdata (end_q),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      register_count <= COUNT_RESET;
    end else if (cfg_write) begin
      register_count <= cfg_data;
    end
  end

  // sequencer, allocation state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      busy_flags       <= '0;
      high_water       <= '0;
      scan_idx         <= '0;
      chk_valid        <= 1'b0;
      found            <= 1'b0;
      result_out.valid <= 1'b0;
    end else begin
      // slot empties on a taken word unless a new word lands at the same edge
      if (result_out.valid && result_out.ready && !commit_go) begin
        result_out.valid <= 1'b0;
      end

      // compare stage follows the read in the cycle after it
      chk_valid <= (state == S_SCAN);
      chk_idx   <= scan_idx;

      if (chk_valid) begin
        if (chk_expire) begin
          busy_flags[chk_idx] <= 1'b0;
        end
        if (chk_free && chk_avail && !found) begin
          found  <= 1'b1;
          chosen <= chk_idx;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            start_q  <= range_in.range_start;
            end_q    <= range_in.range_end;
            scan_idx <= '0;
            found    <= 1'b0;
            if (range_in.first_of_function) begin
              busy_flags <= '0;
              high_water <= '0;
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx == REG_IDX_W'(NUM_REGS - 1)) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + REG_IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // last entry is checked in this cycle
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            result_out.valid            <= 1'b1;
            result_out.no_free_register <= !found;
            if (found) begin
              busy_flags[chosen]           <= 1'b1;
              result_out.assigned_register <= AREG_W'(chosen);
              if (chosen_used > high_water) begin
                high_water                <= chosen_used;
                result_out.registers_used <= USED_W'(chosen_used);
              end else begin
                result_out.registers_used <= USED_W'(high_water);
              end
            end else begin
              result_out.assigned_register <= '0;
              result_out.registers_used    <= USED_W'(high_water);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/lsra_checker.sv
// ----------------------------------------------------------------------------
// lsra_checker
// port-level checks for the linear scan register assigner
// ----------------------------------------------------------------------------
module lsra_checker import lsra_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [AREG_W-1:0] assigned_register,
  input logic              no_free_register,
  input logic [USED_W-1:0] registers_used
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(assigned_register)
      && $stable(no_free_register) && $stable(registers_used))
    else $error("result word changed while stalled");

  // one range at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("range accepted while busy");

  // a failed assignment reports register zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_free_register |-> assigned_register == '0)
    else $error("nonzero register with no free register");

  // high-water covers the register just assigned
  a_used_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_free_register
      |-> USED_W'(assigned_register) < registers_used
       && registers_used <= USED_W'(NUM_REGS))
    else $error("registers_used inconsistent with assignment");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind linear_scan_register_assign lsra_checker u_lsra_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (range_in.valid),
  .in_ready          (range_in.ready),
  .out_valid         (result_out.valid),
  .out_ready         (result_out.ready),
  .assigned_register (result_out.assigned_register),
  .no_free_register  (result_out.no_free_register),
  .registers_used    (result_out.registers_used)
);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks linear scan register assignment against a cycle-free predictor
// ----------------------------------------------------------------------------
// live ranges go in through range_in and every result word from result_out is
// compared field by field with the oldest predicted assignment. a directed
// pass covers position extremes, register handover, a full register set,
// a zero count, a saturating count, a count lowered mid-function and ranges
// that end before they start; random functions with sorted starts and random
// spans follow, mixed with noise, under three idling patterns on both sides.
// ----------------------------------------------------------------------------
module tb;
  import lsra_pkg::*;

  localparam int RANDOM_RANGES = 1100;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int DRAIN_CYCLES  = 80;

  // one predicted result word
  typedef struct packed {
    logic [AREG_W-1:0] reg_idx;
    logic              none_free;
    logic [USED_W-1:0] used;
  } assignment_t;

  // predictor of the assigner plus the queue of assignments still to come
  class assignment_tracker;
    logic [NUM_REGS-1:0]  busy;
    logic [POS_WIDTH-1:0] busy_end [NUM_REGS];
    logic [COUNT_W-1:0]   avail_count;
    int                   high_water;
    assignment_t          pending [$];
    int                   errors;
    int                   results_seen;

    function new();
      busy         = '0;
      avail_count  = COUNT_RESET;
      high_water   = 0;
      errors       = 0;
      results_seen = 0;
      foreach (busy_end[r]) busy_end[r] = '0;
    endfunction

    task report(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
    endtask

    // predict the assignment for a range accepted by the block
    task note_range(input logic first, input logic [POS_WIDTH-1:0] start_pos,
                    input logic [POS_WIDTH-1:0] end_pos);
      int          limit;
      int          pick;
      bit          found;
      assignment_t want;
      limit = (avail_count > NUM_REGS) ? NUM_REGS : int'(avail_count);
      if (first) begin
        busy       = '0;
        high_water = 0;
      end
      // expire everything ending at or before the new start
      for (int r = 0; r < NUM_REGS; r++) begin
        if (busy[r] && busy_end[r] <= start_pos) busy[r] = 1'b0;
      end
      found = 1'b0;
      pick  = 0;
      for (int r = 0; r < limit; r++) begin
        if (!found && !busy[r]) begin
          found = 1'b1;
          pick  = r;
        end
      end
      if (found) begin
        busy[pick]     = 1'b1;
        busy_end[pick] = end_pos;
        if (pick + 1 > high_water) high_water = pick + 1;
      end
      want.reg_idx   = found ? AREG_W'(pick) : '0;
      want.none_free = !found;
      want.used      = USED_W'(high_water);
      pending = {pending, want};
    endtask

    task check_assignment(input assignment_t got);
      assignment_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing pending (reg %0d)", got.reg_idx));
      end else begin
        want = pending.pop_front();
        if (got.reg_idx !== want.reg_idx)
          report($sformatf("assigned_register %0d, want %0d", got.reg_idx, want.reg_idx));
        if (got.none_free !== want.none_free)
          report($sformatf("no_free_register %0b, want %0b", got.none_free,
                           want.none_free));
        if (got.used !== want.used)
          report($sformatf("registers_used %0d, want %0d", got.used, want.used));
      end
      results_seen++;
    endtask
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_write;
  logic [COUNT_W-1:0] cfg_data;

  lsra_in_if  range_in ();
  lsra_out_if result_out ();

  assignment_tracker tracker = new();

  // idle chances in percent, changed per phase by the stimulus
  int send_idle_pct = 28;
  int recv_idle_pct = 72;
  int ranges_sent   = 0;
  int cycles        = 0;

  linear_scan_register_assign i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .range_in   (range_in),
    .result_out (result_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run-away guard, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls, every accepted word goes to the checker
  initial begin
    forever begin
      result_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (!rst && result_out.valid && result_out.ready) begin
        tracker.check_assignment({result_out.assigned_register,
                                  result_out.no_free_register,
                                  result_out.registers_used});
      end
    end
  end

  // hand one range to the block; valid stays up if the next word follows at once
  task automatic send_range(input logic first, input logic [POS_WIDTH-1:0] start_pos,
                            input logic [POS_WIDTH-1:0] end_pos);
    while ($urandom_range(99) < send_idle_pct) begin
      range_in.valid <= 1'b0;
      @(posedge clk);
    end
    range_in.valid             <= 1'b1;
    range_in.first_of_function <= first;
    range_in.range_start       <= start_pos;
    range_in.range_end         <= end_pos;
    @(posedge clk);
    while (!range_in.ready) @(posedge clk);
    tracker.note_range(first, start_pos, end_pos);
    ranges_sent++;
  endtask

  // hold off the sender until every predicted word has come back
  task automatic wait_drained();
    range_in.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  // count register is only touched with the block idle
  task automatic program_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write           <= 1'b0;
    tracker.avail_count  = value;
  endtask

  // one function: mostly sorted starts with random spans, sometimes noise
  task automatic run_function(input int len);
    int                   kind;
    int                   pos;
    int                   step_max;
    int                   span_max;
    logic                 first;
    logic [POS_WIDTH-1:0] start_pos;
    logic [POS_WIDTH-1:0] end_pos;
    kind     = $urandom_range(9);
    step_max = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(1, 200);
    span_max = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(64, 20000);
    pos      = $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        // noise: unordered positions, random function breaks
        first     = $urandom_range(1);
        start_pos = POS_WIDTH'($urandom);
        end_pos   = POS_WIDTH'($urandom);
      end else begin
        // occasional stray function start inside a function
        first = (i == 0) || ($urandom_range(39) == 0);
        // occasional start that jumps out of order
        if ($urandom_range(29) == 0) pos = $urandom_range(0, 65535);
        else pos = pos + $urandom_range(0, step_max);
        if (pos > 65535) pos = 65535;
        start_pos = POS_WIDTH'(pos);
        // end before start now and then, otherwise spans wrap at the top
        if ($urandom_range(15) == 0) end_pos = POS_WIDTH'($urandom_range(0, pos));
        else end_pos = POS_WIDTH'(pos + $urandom_range(0, span_max));
      end
      send_range(first, start_pos, end_pos);
    end
  endtask

  // pick a count, weighted to small sets so the no-free case shows up often
  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COUNT_W'(NUM_REGS);
      2:       return COUNT_W'($urandom_range(NUM_REGS + 1, 127));
      3, 4, 5: return COUNT_W'($urandom_range(1, 8));
      default: return COUNT_W'($urandom_range(1, NUM_REGS));
    endcase
  endfunction

  initial begin
    int phase_base;
    int func_len;
    cfg_write                  <= 1'b0;
    cfg_data                   <= '0;
    range_in.valid             <= 1'b0;
    range_in.first_of_function <= 1'b0;
    range_in.range_start       <= '0;
    range_in.range_end         <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // --- directed: extremes of positions, default count of 64
    send_range(1'b1, 16'd0, 16'd0);
    send_range(1'b0, 16'd0, 16'hFFFF);      // end equal to start hands r0 over
    send_range(1'b0, 16'hFFFF, 16'd0);      // end before start still assigned
    send_range(1'b0, 16'hFFFF, 16'hFFFF);
    send_range(1'b0, 16'hFFFF, 16'hFFFF);

    // overlapping ranges in a fresh function
    send_range(1'b1, 16'd100, 16'd200);
    send_range(1'b0, 16'd150, 16'd300);
    send_range(1'b0, 16'd160, 16'd60000);
    send_range(1'b0, 16'd170, 16'd60000);
    send_range(1'b0, 16'd200, 16'd250);     // exact handover of r0

    // count of two with both low registers busy: no free register
    program_count(COUNT_W'(2));
    send_range(1'b0, 16'd210, 16'd400);
    // count of zero: nothing available even after expiry
    program_count('0);
    send_range(1'b0, 16'd260, 16'd500);
    // count above the register file saturates
    program_count(COUNT_W'(127));
    send_range(1'b0, 16'd300, 16'd1000);
    send_range(1'b0, 16'd301, 16'd1000);
    send_range(1'b0, 16'd302, 16'd1000);
    // count lowered with upper registers still busy
    program_count(COUNT_W'(3));
    send_range(1'b0, 16'd303, 16'd1000);
    send_range(1'b0, 16'd60000, 16'd60001);
    program_count(COUNT_W'(1));
    send_range(1'b0, 16'd60001, 16'd5);
    send_range(1'b1, 16'd0, 16'd0);         // function start clears the busy set

    // --- random functions under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_base = ranges_sent;
      while (ranges_sent - phase_base < RANDOM_RANGES / 3) begin
        // new count between functions, always with the block drained
        if ($urandom_range(2) == 0) program_count(pick_count());
        else wait_drained();
        // keep the phase to its share of ranges
        func_len = $urandom_range(4, 80);
        if (func_len > RANDOM_RANGES / 3 - (ranges_sent - phase_base))
          func_len = RANDOM_RANGES / 3 - (ranges_sent - phase_base);
        run_function(func_len);
      end
    end

    // let the last words come back, then watch for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
